>>> sv/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and widths of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// Widths fixed by the item and result fields
	localparam int BYTE_W   = 8;
	localparam int MODE_W   = 3;
	localparam int CNT_W    = 6;
	localparam int LIDX_W   = 5;
	localparam int KIND_W   = 3;
	localparam int PHASE_W  = 4;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 32;

	// Default buffer depth (2 to 64)
	localparam int BUFFER_DEPTH_DEF = 32;

	// Input modes
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STATUS = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd4;

	// Reply kinds
	localparam logic [KIND_W-1:0] KIND_CMD     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WDONE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RBYTE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

	// Transfer phases
	localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RD_START = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RD_ADDR  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_RD_BYTES = 4'd3;
	localparam logic [PHASE_W-1:0] PH_RD_LAST  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_RD_DONE  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_WR_START = 4'd6;
	localparam logic [PHASE_W-1:0] PH_WR_ADDR  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_WR_DATA  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_WR_DONE  = 4'd9;

	// TWI status codes (prescaler bits masked off)
	localparam logic [BYTE_W-1:0] STS_MASK       = 8'hF8;
	localparam logic [BYTE_W-1:0] STS_START      = 8'h08;
	localparam logic [BYTE_W-1:0] STS_RSTART     = 8'h10;
	localparam logic [BYTE_W-1:0] STS_MT_SLA_ACK = 8'h18;
	localparam logic [BYTE_W-1:0] STS_MT_DAT_ACK = 8'h28;
	localparam logic [BYTE_W-1:0] STS_MR_SLA_ACK = 8'h40;
	localparam logic [BYTE_W-1:0] STS_MR_DAT_ACK = 8'h50;
	localparam logic [BYTE_W-1:0] STS_MR_DAT_NAK = 8'h58;
	localparam logic [BYTE_W-1:0] STS_SR_DAT_ACK = 8'h80;
	localparam logic [BYTE_W-1:0] STS_SR_DAT_NAK = 8'h88;

	// Address byte with the direction bit cleared
	localparam logic [BYTE_W-1:0] ADDR_MASK = 8'hFE;

	// One input item
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] device_address;
		logic [CNT_W-1:0]  transfer_length;
		logic [LIDX_W-1:0] load_index;
		logic [BYTE_W-1:0] load_value;
		logic [BYTE_W-1:0] bus_status;
		logic [BYTE_W-1:0] received_byte;
	} item_t;

	// One result item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_value;
		logic              send_start;
		logic              send_stop;
		logic              ack_next;
		logic              irq_enable;
		logic              success;
		logic [BYTE_W-1:0] read_value;
		logic [CNT_W-1:0]  read_count;
		logic              last;
	} result_t;

endpackage

>>> sv/i2cms_ram.sv
// ----------------------------------------------------------------------------
// i2cms_ram
// Byte buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2cms_ram #(
	parameter int DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF,
	parameter int WIDTH = i2cms_pkg::BYTE_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer sequencer: takes one item, reads the buffers, forms the reply,
// writes back, and streams the received bytes after a completed read.
// ----------------------------------------------------------------------------
module i2cms_ctrl #(
	parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  i2cms_pkg::item_t        in_item,
	output logic                    res_valid,
	input  logic                    res_ready,
	output i2cms_pkg::result_t      res
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = i2cms_pkg::CNT_W;
	localparam logic [CW:0] DEPTH_V = (CW+1)'(BUFFER_DEPTH);

	// sequencer states
	localparam logic [1:0] S_ACC  = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_RB   = 2'd3;

	logic [1:0]                        st_q;
	logic [i2cms_pkg::PHASE_W-1:0]     phase_q, phase_d;
	logic [i2cms_pkg::BYTE_W-1:0]      target_q, target_d;
	logic [CW-1:0]                     count_q, count_d;
	logic [CW-1:0]                     pos_q, pos_d, pos_inc, pos_inc2;
	logic [CW-1:0]                     idx_q, idx_inc;
	i2cms_pkg::item_t                  item_q;
	i2cms_pkg::result_t                exec_res, strm_res;
	logic [i2cms_pkg::BYTE_W-1:0]      sts;
	logic [i2cms_pkg::BYTE_W-1:0]      tx_rdata, rx_rdata;
	logic [AW-1:0]                     tx_raddr, tx_waddr, rx_waddr, rx_raddr;
	logic [CW:0]                       lidx_ext;
	logic                              tx_we, rx_we, rx_we_c, tx_we_c;
	logic                              go_stream, commit, strm_last;

	assign pos_inc  = pos_q + CW'(1);
	assign pos_inc2 = pos_inc + CW'(1);
	assign idx_inc  = idx_q + CW'(1);
	assign sts      = item_q.bus_status & i2cms_pkg::STS_MASK;
	assign lidx_ext = (CW+1)'(item_q.load_index);

	// buffer addresses: next write byte, load slot, receive slot, stream slot
	assign tx_raddr = (phase_q == i2cms_pkg::PH_WR_DATA) ? pos_inc[AW-1:0] : '0;
	assign tx_waddr = lidx_ext[AW-1:0];
	assign rx_waddr = pos_q[AW-1:0];
	assign rx_raddr = idx_q[AW-1:0];

	// reply and next state for the held item
	always_comb begin
		exec_res            = '0;
		exec_res.kind       = i2cms_pkg::KIND_NONE;
		exec_res.last       = 1'b1;
		phase_d             = phase_q;
		target_d            = target_q;
		count_d             = count_q;
		pos_d               = pos_q;
		tx_we_c             = 1'b0;
		rx_we_c             = 1'b0;
		go_stream           = 1'b0;
		unique case (item_q.mode)
			i2cms_pkg::MODE_READ, i2cms_pkg::MODE_WRITE: begin
				if (phase_q != i2cms_pkg::PH_IDLE || item_q.transfer_length == '0 ||
				    (CW+1)'(item_q.transfer_length) > DEPTH_V) begin
					exec_res.kind = i2cms_pkg::KIND_REFUSED;
				end else begin
					target_d = item_q.device_address & i2cms_pkg::ADDR_MASK;
					count_d  = item_q.transfer_length;
					phase_d  = (item_q.mode == i2cms_pkg::MODE_READ) ?
					           i2cms_pkg::PH_RD_START : i2cms_pkg::PH_WR_START;
					exec_res.kind       = i2cms_pkg::KIND_CMD;
					exec_res.send_start = 1'b1;
					exec_res.irq_enable = 1'b1;
				end
			end
			i2cms_pkg::MODE_LOAD: begin
				tx_we_c = (lidx_ext < DEPTH_V);
			end
			i2cms_pkg::MODE_STATUS: begin
				if (sts == i2cms_pkg::STS_START || sts == i2cms_pkg::STS_RSTART) begin
					if (phase_q == i2cms_pkg::PH_RD_START) begin
						phase_d             = i2cms_pkg::PH_RD_ADDR;
						exec_res.kind       = i2cms_pkg::KIND_CMD;
						exec_res.tx_valid   = 1'b1;
						exec_res.tx_value   = target_q | 8'h01;
						exec_res.irq_enable = 1'b1;
					end else if (phase_q == i2cms_pkg::PH_WR_START) begin
						phase_d             = i2cms_pkg::PH_WR_ADDR;
						exec_res.kind       = i2cms_pkg::KIND_CMD;
						exec_res.tx_valid   = 1'b1;
						exec_res.tx_value   = target_q;
						exec_res.irq_enable = 1'b1;
					end
				end else if (sts == i2cms_pkg::STS_MT_SLA_ACK ||
				             sts == i2cms_pkg::STS_MR_SLA_ACK) begin
					if (phase_q == i2cms_pkg::PH_RD_ADDR) begin
						pos_d               = '0;
						exec_res.kind       = i2cms_pkg::KIND_CMD;
						exec_res.irq_enable = 1'b1;
						if (count_q != CW'(1)) begin
							phase_d           = i2cms_pkg::PH_RD_BYTES;
							exec_res.ack_next = 1'b1;
						end else begin
							phase_d = i2cms_pkg::PH_RD_LAST;
						end
					end else if (phase_q == i2cms_pkg::PH_WR_ADDR) begin
						pos_d               = '0;
						phase_d             = i2cms_pkg::PH_WR_DATA;
						exec_res.kind       = i2cms_pkg::KIND_CMD;
						exec_res.tx_valid   = 1'b1;
						exec_res.tx_value   = tx_rdata;
						exec_res.ack_next   = 1'b1;
						exec_res.irq_enable = 1'b1;
					end
				end else if (sts == i2cms_pkg::STS_MT_DAT_ACK) begin
					if (phase_q == i2cms_pkg::PH_WR_DATA) begin
						exec_res.kind = i2cms_pkg::KIND_CMD;
						if (count_q != pos_inc) begin
							pos_d               = pos_inc;
							exec_res.tx_valid   = 1'b1;
							exec_res.tx_value   = tx_rdata;
							exec_res.ack_next   = 1'b1;
							exec_res.irq_enable = 1'b1;
						end else begin
							phase_d            = i2cms_pkg::PH_WR_DONE;
							exec_res.send_stop = 1'b1;
						end
					end
				end else if (sts == i2cms_pkg::STS_MR_DAT_ACK ||
				             sts == i2cms_pkg::STS_SR_DAT_ACK) begin
					if (phase_q == i2cms_pkg::PH_RD_BYTES) begin
						rx_we_c             = 1'b1;
						pos_d               = pos_inc;
						exec_res.kind       = i2cms_pkg::KIND_CMD;
						exec_res.irq_enable = 1'b1;
						if (pos_inc2 == count_q) begin
							phase_d = i2cms_pkg::PH_RD_LAST;
						end else begin
							exec_res.ack_next = 1'b1;
						end
					end
				end else if (sts == i2cms_pkg::STS_MR_DAT_NAK ||
				             sts == i2cms_pkg::STS_SR_DAT_NAK) begin
					if (phase_q == i2cms_pkg::PH_RD_LAST) begin
						rx_we_c            = 1'b1;
						phase_d            = i2cms_pkg::PH_RD_DONE;
						exec_res.kind      = i2cms_pkg::KIND_CMD;
						exec_res.send_stop = 1'b1;
					end
				end
			end
			i2cms_pkg::MODE_TICK: begin
				if (phase_q == i2cms_pkg::PH_WR_DONE) begin
					phase_d          = i2cms_pkg::PH_IDLE;
					exec_res.kind    = i2cms_pkg::KIND_WDONE;
					exec_res.success = 1'b1;
				end else if (phase_q == i2cms_pkg::PH_RD_DONE) begin
					phase_d   = i2cms_pkg::PH_IDLE;
					go_stream = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// one received byte of the completed read
	assign strm_last = (idx_inc == count_q);
	always_comb begin
		strm_res            = '0;
		strm_res.kind       = i2cms_pkg::KIND_RBYTE;
		strm_res.success    = 1'b1;
		strm_res.read_value = rx_rdata;
		strm_res.read_count = count_q;
		strm_res.last       = strm_last;
	end

	// handshake with the output stage
	assign in_ready  = (st_q == S_ACC);
	assign res_valid = (st_q == S_RB) || (st_q == S_EXEC && !go_stream);
	assign res       = (st_q == S_RB) ? strm_res : exec_res;
	assign commit    = (st_q == S_EXEC) && (go_stream || res_ready);
	assign tx_we     = commit && tx_we_c;
	assign rx_we     = commit && rx_we_c;

	// item hold register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
	end

	// sequencer and transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_ACC;
			phase_q  <= i2cms_pkg::PH_IDLE;
			target_q <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
		end else begin
			unique case (st_q)
				S_ACC: begin
					if (in_valid) begin
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						phase_q  <= phase_d;
						target_q <= target_d;
						count_q  <= count_d;
						pos_q    <= pos_d;
						idx_q    <= '0;
						st_q     <= go_stream ? S_RD : S_ACC;
					end
				end
				S_RD: begin
					st_q <= S_RB;
				end
				S_RB: begin
					if (res_ready) begin
						if (strm_last) begin
							st_q <= S_ACC;
						end else begin
							idx_q <= idx_inc;
							st_q  <= S_RD;
						end
					end
				end
				default: begin
					st_q <= S_ACC;
				end
			endcase
		end
	end

	// write buffer
	i2cms_ram #(
		.DEPTH (BUFFER_DEPTH),
		.WIDTH (i2cms_pkg::BYTE_W)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (item_q.load_value),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	// receive buffer
	i2cms_ram #(
		.DEPTH (BUFFER_DEPTH),
		.WIDTH (i2cms_pkg::BYTE_W)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (item_q.received_byte),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

endmodule

>>> sv/i2c_master_transfer_sequencer_top.sv
// An item is taken in the accept state; its reply is formed in the execute
// state, once the buffer memory's registered read data is back. A tick after
// a completed read streams the received bytes, each read from the receive
// buffer and then held until the output accepts it; the last one carries
// tlast. The next item is taken while a reply waits in the output register.
// The byte buffers are not cleared after reset; no start-up pass.
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// I2C master read and write sequencer driven by TWI status events.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top #(
	parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [7:0] device_address, [13:8] transfer_length, [18:14] load_index,
	// [26:19] load_value, [34:27] bus_status, [42:35] received_byte
	input  logic [i2cms_pkg::S_DATA_W-1:0]   s_tdata,
	// [2:0] mode
	input  logic [i2cms_pkg::MODE_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] tx_valid, [8:1] tx_value, [9] send_start, [10] send_stop,
	// [11] ack_next, [12] irq_enable, [13] success, [21:14] read_value,
	// [27:22] read_count
	output logic [i2cms_pkg::M_DATA_W-1:0]   m_tdata,
	// [2:0] reply_kind
	output logic [i2cms_pkg::KIND_W-1:0]     m_tuser,
	output logic                             m_tlast
);

	i2cms_pkg::item_t   in_item;
	i2cms_pkg::result_t res, out_q;
	logic               res_valid, res_ready, out_valid_q;

	// unpack the slave-side transfer
	always_comb begin
		in_item                 = '0;
		in_item.mode            = s_tuser;
		in_item.device_address  = s_tdata[7:0];
		in_item.transfer_length = s_tdata[13:8];
		in_item.load_index      = s_tdata[18:14];
		in_item.load_value      = s_tdata[26:19];
		in_item.bus_status      = s_tdata[34:27];
		in_item.received_byte   = s_tdata[42:35];
	end

	i2cms_ctrl #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// pack the master-side transfer
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {4'b0, out_q.read_count, out_q.read_value, out_q.success,
	                   out_q.irq_enable, out_q.ack_next, out_q.send_stop,
	                   out_q.send_start, out_q.tx_value, out_q.tx_valid};

`ifndef SYNTHESIS
	// an item is taken only when no reply is being formed
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("item taken while a reply is pending");

	// one item at a time: no transfer in the cycle after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken before the first was processed");

	// every reply other than a read byte closes its item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind != i2cms_pkg::KIND_RBYTE) |-> res.last)
		else $error("single reply without last marker");
`endif

endmodule
